>>> sv/prime_test_and_greatest_factor_macros.svh
// Assertion macros for the trial division block.
// Both expect clk and rst_n in scope at the point of use.
`ifndef PRIME_TEST_AND_GREATEST_FACTOR_MACROS_SVH
`define PRIME_TEST_AND_GREATEST_FACTOR_MACROS_SVH

`ifndef SYNTH
`define PTGF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PTGF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTGF_ASSERT_NOW(label, ante, cons)
`define PTGF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/ptgf_pkg.sv
package ptgf_pkg;

  localparam int PTGF_VALUE_BITS  = 32;
  localparam int PTGF_IN_BITS     = 32;
  localparam int PTGF_ANSWER_BITS = 32;

  localparam logic MODE_PRIME  = 1'b0;
  localparam logic MODE_FACTOR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE
  } ptgf_state_t;

endpackage

>>> sv/prime_test_and_greatest_factor.sv
// Values below 2 are answered directly from idle; otherwise each trial divisor tried
// takes a serial divide (one restoring-division bit per cycle) and then a decision state.
// One request at a time; busy stays high while the single bit-serial divider, shared by
// all trial divisors, works through the value.
// Reset: synchronous, active low rst_n; returns to idle and drops out_valid.
// out_valid pulses for one cycle; the receiver cannot stall.
`include "prime_test_and_greatest_factor_macros.svh"

module prime_test_and_greatest_factor
  import ptgf_pkg::*;
#(
  parameter int VALUE_BITS = PTGF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [PTGF_IN_BITS-1:0]     in_value,
  output logic                        out_valid,
  output logic [PTGF_ANSWER_BITS-1:0] out_answer
);

  // Width that holds both the working value and the answer field.
  localparam int WIDE_BITS = (VALUE_BITS > PTGF_ANSWER_BITS) ? VALUE_BITS : PTGF_ANSWER_BITS;
  localparam int CNT_W     = $clog2(VALUE_BITS);

  ptgf_state_t state_r, state_nxt;

  // rest_r  : value still being factored (the original value in prime mode)
  // div_r   : current trial divisor
  // dvd_r   : dividend shifting out at the top, quotient shifting in at the bottom
  // rem_r   : partial remainder of the serial divide
  logic [VALUE_BITS-1:0] rest_r, rest_nxt;
  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  mode_r, mode_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [PTGF_ANSWER_BITS-1:0] out_answer_r, out_answer_nxt;

  // One restoring-division step: shift in the next dividend bit, subtract if it fits.
  logic [VALUE_BITS:0] shifted;
  logic [VALUE_BITS:0] diff;
  logic                fits;

  logic [WIDE_BITS-1:0]  in_wide;
  logic [VALUE_BITS-1:0] in_num;
  logic [WIDE_BITS-1:0]  rest_wide;

  assign shifted = {rem_r, dvd_r[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign fits    = (shifted >= {1'b0, div_r});

  // Input reduced to the working width; answer taken as the low 32 bits of rest.
  assign in_wide   = WIDE_BITS'(in_value);
  assign in_num    = in_wide[VALUE_BITS-1:0];
  assign rest_wide = WIDE_BITS'(rest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r       <= rest_nxt;
    div_r        <= div_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    mode_r       <= mode_nxt;
    out_answer_r <= out_answer_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rest_nxt       = rest_r;
    div_nxt        = div_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    mode_nxt       = mode_r;
    out_valid_nxt  = 1'b0;
    out_answer_nxt = out_answer_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          rest_nxt = in_num;
          if (in_num < VALUE_BITS'(2)) begin
            // zero and one: not prime, greatest factor reported as 2
            out_valid_nxt  = 1'b1;
            out_answer_nxt = (in_mode == MODE_FACTOR) ? PTGF_ANSWER_BITS'(2)
                                                      : '0;
          end else begin
            div_nxt   = VALUE_BITS'(2);
            dvd_nxt   = in_num;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(VALUE_BITS - 1);
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        dvd_nxt = {dvd_r[VALUE_BITS-2:0], fits};
        rem_nxt = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        // dvd_r = rest / div, rem_r = rest % div
        rem_nxt = '0;
        cnt_nxt = CNT_W'(VALUE_BITS - 1);
        if (div_r > dvd_r) begin
          // divisor past the square root: no more factors below it
          out_valid_nxt  = 1'b1;
          out_answer_nxt = (mode_r == MODE_FACTOR) ? rest_wide[PTGF_ANSWER_BITS-1:0]
                                                   : PTGF_ANSWER_BITS'(1);
          state_nxt      = ST_IDLE;
        end else if (rem_r == '0) begin
          if (mode_r == MODE_FACTOR) begin
            // divide the factor out, retry the same divisor
            rest_nxt  = dvd_r;
            dvd_nxt   = dvd_r;
            state_nxt = ST_DIV;
          end else begin
            out_valid_nxt  = 1'b1;
            out_answer_nxt = '0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          div_nxt   = div_r + VALUE_BITS'(1);
          dvd_nxt   = rest_r;
          state_nxt = ST_DIV;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;

  `PTGF_ASSERT_NEXT(a_accept_busy, start && !busy && (in_num >= VALUE_BITS'(2)), busy)
  `PTGF_ASSERT_NOW(a_result_idle, out_valid, !busy)
  `PTGF_ASSERT_NOW(a_prime_flag, out_valid && (mode_r == MODE_PRIME), out_answer <= PTGF_ANSWER_BITS'(1))
  `PTGF_ASSERT_NOW(a_div_min, state_r == ST_DECIDE, div_r >= VALUE_BITS'(2))
  `PTGF_ASSERT_NOW(a_rem_below, state_r == ST_DECIDE, rem_r < div_r)

endmodule

>>> verif/prime_test_and_greatest_factor_tb.sv
module prime_test_and_greatest_factor_tb;
  import ptgf_pkg::*;

  // One divider step per value bit plus a decision state for every trial divisor.
  localparam int VALUE_BITS      = PTGF_VALUE_BITS;
  localparam int STEP_CYCLES     = VALUE_BITS + 1;
  // Random values are kept to at most this many trial divisors so the run stays short.
  localparam int TRIAL_CAP       = 300;
  // Longest legal quiet stretch is one capped request plus a sender gap; allow 4x.
  localparam int WATCHDOG_CYCLES = 4 * (TRIAL_CAP + 4) * STEP_CYCLES;
  localparam int TAIL_CYCLES     = 2 * STEP_CYCLES + 8;
  localparam int RANDOM_REQUESTS = 77;
  localparam int GAP_MAX         = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_DIRECTED    = 23;

  typedef struct packed {
    logic                        mode;
    logic [PTGF_IN_BITS-1:0]     value;
    logic [PTGF_ANSWER_BITS-1:0] answer;
  } pending_answer_t;

  // typed = 1: answer is read off directly; otherwise the predictor supplies it.
  typedef struct packed {
    logic                        mode;
    logic [PTGF_IN_BITS-1:0]     value;
    bit                          typed;
    logic [PTGF_ANSWER_BITS-1:0] answer;
  } directed_row_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        start      = 1'b0;
  logic                        in_mode    = MODE_PRIME;
  logic [PTGF_IN_BITS-1:0]     in_value   = '0;
  logic                        busy;
  logic                        out_valid;
  logic [PTGF_ANSWER_BITS-1:0] out_answer;

  pending_answer_t pending_answers[$];
  pending_answer_t oldest;

  int unsigned failures       = 0;
  int unsigned results_seen   = 0;
  int unsigned prime_tests    = 0;
  int unsigned factorings     = 0;
  int unsigned wide_values    = 0;
  int unsigned quiet_cycles   = 0;

  // Directed requests: both ends of the value range, zero and one in each mode,
  // the two smallest primes, squares of primes (divisor equal to the root),
  // the largest 16-bit prime, and alternating bit patterns.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{MODE_PRIME,  32'd0,          1'b1, 32'd0},
    '{MODE_PRIME,  32'd1,          1'b1, 32'd0},
    '{MODE_FACTOR, 32'd0,          1'b1, 32'd2},
    '{MODE_FACTOR, 32'd1,          1'b1, 32'd2},
    '{MODE_PRIME,  32'd2,          1'b1, 32'd1},
    '{MODE_FACTOR, 32'd2,          1'b1, 32'd2},
    '{MODE_PRIME,  32'd3,          1'b1, 32'd1},
    '{MODE_FACTOR, 32'd3,          1'b1, 32'd3},
    '{MODE_PRIME,  32'd4,          1'b1, 32'd0},
    '{MODE_FACTOR, 32'd4,          1'b1, 32'd2},
    '{MODE_PRIME,  32'd9,          1'b0, 32'd0},
    '{MODE_FACTOR, 32'd9,          1'b0, 32'd0},
    '{MODE_PRIME,  32'd49,         1'b0, 32'd0},
    '{MODE_PRIME,  32'd65521,      1'b0, 32'd0},
    '{MODE_FACTOR, 32'd65521,      1'b0, 32'd0},
    '{MODE_PRIME,  32'hFFFF_FFFF,  1'b1, 32'd0},
    '{MODE_FACTOR, 32'hFFFF_FFFF,  1'b0, 32'd0},
    '{MODE_PRIME,  32'h8000_0000,  1'b1, 32'd0},
    '{MODE_FACTOR, 32'h8000_0000,  1'b1, 32'd2},
    '{MODE_PRIME,  32'hFFFF_FFFE,  1'b1, 32'd0},
    '{MODE_FACTOR, 32'hAAAA_AAAA,  1'b0, 32'd0},
    '{MODE_PRIME,  32'h5555_5555,  1'b0, 32'd0},
    '{MODE_FACTOR, 32'd360,        1'b0, 32'd0}
  };

  prime_test_and_greatest_factor #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_answer(out_answer)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor: primality flag or greatest prime factor by trial division.
  // Also reports how many divisors were tried, which sets the block's run time.
  function automatic logic [PTGF_ANSWER_BITS-1:0] trial_division_answer(
    input  logic                    mode,
    input  logic [PTGF_IN_BITS-1:0] value,
    output int unsigned             trials
  );
    longint unsigned work_mask;
    longint unsigned num;
    longint unsigned rest;
    longint unsigned div;
    bit              is_prime;
    work_mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    num       = 64'(value) & work_mask;
    trials    = 0;
    if (mode == MODE_PRIME) begin
      // zero and one are not prime
      is_prime = (num >= 64'd2);
      for (div = 2; is_prime && div <= num / div; div++) begin
        trials++;
        if (num % div == 0) is_prime = 1'b0;
      end
      return is_prime ? PTGF_ANSWER_BITS'(1) : PTGF_ANSWER_BITS'(0);
    end
    // zero and one factor to two
    if (num < 64'd2) return PTGF_ANSWER_BITS'(2);
    rest = num;
    div  = 2;
    while (div <= rest / div) begin
      trials++;
      if (rest % div == 0) rest = rest / div;
      else div++;
    end
    return rest[PTGF_ANSWER_BITS-1:0];
  endfunction

  // Random value of a mixed shape, retried until the trial count fits the cap (at most 64 tries,
  // then the low byte of the last value). Full-width values land mostly on fast composites in
  // prime-test mode; shifted and product shapes give large values with small factors.
  function automatic logic [PTGF_IN_BITS-1:0] pick_value(input logic mode);
    int unsigned                 trials;
    int unsigned                 shape;
    logic [PTGF_IN_BITS-1:0]     v;
    logic [PTGF_ANSWER_BITS-1:0] ans;
    v = '0;
    for (int tries = 0; tries < 64; tries++) begin
      shape = $urandom_range(0, 99);
      if (shape < 20)      v = $urandom_range(0, 255);
      else if (shape < 50) v = $urandom_range(0, 65535);
      else if (shape < 70) v = $urandom();
      else if (shape < 85) v = $urandom_range(1, 4095) << $urandom_range(0, 20);
      else                 v = $urandom_range(2, 4095) * $urandom_range(2, 4095);
      ans = trial_division_answer(mode, v, trials);
      if (trials <= TRIAL_CAP) return v;
    end
    return v & 32'hFF;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Present one request and hold it until the block takes it (start high, busy low).
  // start is left high; the caller either presents the next request or pauses.
  task automatic issue_request(
    input logic                        mode,
    input logic [PTGF_IN_BITS-1:0]     value,
    input bit                          typed,
    input logic [PTGF_ANSWER_BITS-1:0] typed_answer
  );
    int unsigned                 trials;
    logic [PTGF_ANSWER_BITS-1:0] answer;
    start    <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    answer = typed ? typed_answer : trial_division_answer(mode, value, trials);
    do @(posedge clk); while (busy);
    pending_answers.push_back('{mode, value, answer});
    if (mode == MODE_PRIME) prime_tests++;
    else factorings++;
    if (value > 32'h0000_FFFF) wide_values++;
  endtask

  // Sender gap: start low for a random number of cycles, about 26 requests in 100.
  task automatic maybe_pause(input bit idling_on);
    if (idling_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
  endtask

  // Result checker: every strobe must match the oldest outstanding request.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        note_failure($sformatf("answer %0d with no request outstanding", out_answer));
      end else begin
        oldest = pending_answers.pop_front();
        results_seen++;
        if (out_answer !== oldest.answer)
          note_failure($sformatf("mode %0d value %0d: answer exp %0d got %0d",
                                 oldest.mode, oldest.value, oldest.answer, out_answer));
      end
    end
  end

  // Watchdog: counts cycles without a request taken or a result strobed.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles, %0d answers outstanding",
               quiet_cycles, pending_answers.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic req_mode;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, with gaps
    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].mode, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].answer);
      maybe_pause(1'b1);
    end

    // random part; requests 40..69 go back to back
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      req_mode = $urandom_range(0, 1);
      issue_request(req_mode, pick_value(req_mode), 1'b0, '0);
      maybe_pause(!(n >= 40 && n < 70));
    end
    start <= 1'b0;

    // drain, then watch for stray strobes
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d prime tests and %0d factorings, %0d of them above 16 bits;",
             prime_tests, factorings, wide_values);
    $display("checked %0d answers, %0d failures.", results_seen, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> prime_test_and_greatest_factor.f
+incdir+sv
sv/ptgf_pkg.sv
sv/prime_test_and_greatest_factor.sv
verif/prime_test_and_greatest_factor_tb.sv
